/* hdl/ckre_pkg.sv */
// Shared types and constants for the color key run extractor.
package ckre_pkg;

    localparam int MAX_WIDTH     = 4096;
    localparam int MAX_HEIGHT    = 4096;
    localparam int PALETTE_DEPTH = 256;

    localparam int WORD_W  = 32;
    localparam int KEY_W   = 24;
    localparam int SLOT_W  = 8;
    localparam int COL_W   = 12;
    localparam int RIGHT_W = 13;
    localparam int ROW_W   = 12;
    localparam int CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_COLOR    = 2'd0,
        REG_PIXEL_FORMAT = 2'd1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        FMT_PAL8  = 2'd0,
        FMT_RGB16 = 2'd1,
        FMT_RGB24 = 2'd2,
        FMT_RGB32 = 2'd3
    } pix_fmt_t;

    typedef enum logic {
        OP_PIXEL     = 1'b0,
        OP_PAL_WRITE = 1'b1
    } opcode_t;

    // One classified pixel handed from the compare stage to the run tracker
    typedef struct packed {
        logic valid;
        logic opaque;
        logic row_end;
        logic frame_start;
    } pix_info_t;

endpackage

/* hdl/ckre_palette.sv */
// Palette store: one write port, one registered read port.
module ckre_palette (
    input  logic                          aclk,
    input  logic                          wr_en,
    input  logic [ckre_pkg::SLOT_W-1:0]   wr_addr,
    input  logic [ckre_pkg::WORD_W-1:0]   wr_data,
    input  logic                          rd_en,
    input  logic [ckre_pkg::SLOT_W-1:0]   rd_addr,
    output logic [ckre_pkg::WORD_W-1:0]   rd_data
);

    logic [ckre_pkg::WORD_W-1:0] mem [ckre_pkg::PALETTE_DEPTH];
    logic [ckre_pkg::WORD_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en && (int'(wr_addr) < ckre_pkg::PALETTE_DEPTH)) begin
            mem[wr_addr] <= wr_data;
        end
        // out-of-range reads are masked by the caller
        if (rd_en && (int'(rd_addr) < ckre_pkg::PALETTE_DEPTH)) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hdl/ckre_run_tracker.sv */
// Row/column counters, run state and the result register.
module ckre_run_tracker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  ckre_pkg::pix_info_t            pix,
    output logic                           pix_take,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [ckre_pkg::COL_W-1:0]     m_run_left,
    output logic [ckre_pkg::RIGHT_W-1:0]   m_run_right,
    output logic [ckre_pkg::ROW_W-1:0]     m_run_row
);

    logic [ckre_pkg::RIGHT_W-1:0] column_reg, column_next;
    logic [ckre_pkg::ROW_W-1:0]   row_reg, row_next;
    logic                         open_reg, open_next;
    logic [ckre_pkg::COL_W-1:0]   start_reg, start_next;

    logic                         m_valid_reg, m_valid_next;
    logic [ckre_pkg::COL_W-1:0]   left_reg, left_next;
    logic [ckre_pkg::RIGHT_W-1:0] right_reg, right_next;
    logic [ckre_pkg::ROW_W-1:0]   out_row_reg, out_row_next;

    logic [ckre_pkg::RIGHT_W-1:0] col_base;
    logic [ckre_pkg::ROW_W-1:0]   row_base;
    logic [ckre_pkg::ROW_W:0]     row_inc;
    logic                         open_base;
    logic                         line_end;
    logic                         emit;
    logic                         out_free;
    logic                         open_now;
    logic [ckre_pkg::COL_W-1:0]   start_now;
    logic [ckre_pkg::COL_W-1:0]   emit_left;
    logic [ckre_pkg::RIGHT_W-1:0] emit_right;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        // frame start clears position and drops an open run before the pixel
        col_base  = pix.frame_start ? '0 : column_reg;
        row_base  = pix.frame_start ? '0 : row_reg;
        open_base = pix.frame_start ? 1'b0 : open_reg;
        line_end  = pix.row_end || (int'(col_base) >= ckre_pkg::MAX_WIDTH - 1);
        row_inc   = {1'b0, row_base} + 1'b1;

        emit       = 1'b0;
        emit_left  = start_reg;
        emit_right = col_base;
        open_now   = open_base;
        start_now  = start_reg;

        if (open_base) begin
            if (!pix.opaque) begin
                emit     = 1'b1;
                open_now = 1'b0;
            end
        end else if (pix.opaque) begin
            start_now = col_base[ckre_pkg::COL_W-1:0];
            open_now  = 1'b1;
        end

        if (line_end && open_now && pix.opaque) begin
            emit       = 1'b1;
            emit_left  = start_now;
            emit_right = col_base + 1'b1;
        end
    end

    assign pix_take = pix.valid && (!emit || out_free);

    always_comb begin
        column_next  = column_reg;
        row_next     = row_reg;
        open_next    = open_reg;
        start_next   = start_reg;
        m_valid_next = m_valid_reg && !m_ready;
        left_next    = left_reg;
        right_next   = right_reg;
        out_row_next = out_row_reg;

        if (pix_take) begin
            start_next = start_now;
            if (line_end) begin
                open_next   = 1'b0;
                column_next = '0;
                row_next    = (int'(row_inc) >= ckre_pkg::MAX_HEIGHT) ? '0
                                                                 : row_inc[ckre_pkg::ROW_W-1:0];
            end else begin
                open_next   = open_now;
                column_next = col_base + 1'b1;
                row_next    = row_base;
            end
            if (emit) begin
                m_valid_next = 1'b1;
                left_next    = emit_left;
                right_next   = emit_right;
                out_row_next = row_base;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_reg  <= '0;
            row_reg     <= '0;
            open_reg    <= 1'b0;
            start_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            column_reg  <= column_next;
            row_reg     <= row_next;
            open_reg    <= open_next;
            start_reg   <= start_next;
            m_valid_reg <= m_valid_next;
        end
        left_reg    <= left_next;
        right_reg   <= right_next;
        out_row_reg <= out_row_next;
    end

    assign m_valid     = m_valid_reg;
    assign m_run_left  = left_reg;
    assign m_run_right = right_reg;
    assign m_run_row   = out_row_reg;

endmodule

/* hdl/color_key_run_extractor_core.sv */
// Top level: config registers, pixel input stage and key compare.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-------------------------------------
//  cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//  s        | in        | s_valid / s_ready     | opcode, pixel_word, palette_slot,
//           |           |                       | row_end, frame_start
//  m        | out       | m_valid / m_ready     | run_left, run_right, run_row
//
// One transaction per cycle sustained while no run result waits on a stalled m channel;
// a pixel passes the input stage (with the registered palette read), and its run then
// lands in the result register. A palette write takes effect at its own accept edge.
// Reset clears counters, run state, valids and config (key 0, 32-bit format).
// A pixel that closes a run holds in the input stage, and s_ready drops, while the
// previous run result waits on a stalled m channel.
module color_key_run_extractor_core (
    input  logic                             aclk,
    input  logic                             aresetn,

    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ckre_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [ckre_pkg::KEY_W-1:0]       cfg_data,

    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [ckre_pkg::WORD_W-1:0]      s_pixel_word,
    input  logic [ckre_pkg::SLOT_W-1:0]      s_palette_slot,
    input  logic                             s_row_end,
    input  logic                             s_frame_start,

    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [ckre_pkg::COL_W-1:0]       m_run_left,
    output logic [ckre_pkg::RIGHT_W-1:0]     m_run_right,
    output logic [ckre_pkg::ROW_W-1:0]       m_run_row
);

    logic [ckre_pkg::KEY_W-1:0] key_reg, key_next;
    ckre_pkg::pix_fmt_t         fmt_reg, fmt_next;

    logic                        s1_valid_reg, s1_valid_next;
    logic [ckre_pkg::WORD_W-1:0] s1_word_reg, s1_word_next;
    logic                        s1_row_end_reg, s1_row_end_next;
    logic                        s1_frame_start_reg, s1_frame_start_next;

    logic                        s_take;
    logic                        is_pixel;
    logic                        pix_take;
    logic [ckre_pkg::WORD_W-1:0] pal_entry;
    logic [ckre_pkg::WORD_W-1:0] pal_value;
    logic [ckre_pkg::KEY_W-1:0]  key_rgb;
    logic [15:0]                 key_565;
    logic                        opaque;
    ckre_pkg::pix_info_t         pix;

    assign cfg_ready = 1'b1;

    always_comb begin
        key_next = key_reg;
        fmt_next = fmt_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                ckre_pkg::REG_KEY_COLOR:    key_next = cfg_data;
                ckre_pkg::REG_PIXEL_FORMAT: fmt_next = ckre_pkg::pix_fmt_t'(cfg_data[1:0]);
                default: ;
            endcase
        end
    end

    assign s_ready  = !s1_valid_reg || pix_take;
    assign s_take   = s_valid && s_ready;
    assign is_pixel = (s_opcode == ckre_pkg::OP_PIXEL);

    always_comb begin
        s1_valid_next       = s1_valid_reg && !pix_take;
        s1_word_next        = s1_word_reg;
        s1_row_end_next     = s1_row_end_reg;
        s1_frame_start_next = s1_frame_start_reg;
        // palette writes finish at accept and never enter the stage
        if (s_take && is_pixel) begin
            s1_valid_next       = 1'b1;
            s1_word_next        = s_pixel_word;
            s1_row_end_next     = s_row_end;
            s1_frame_start_next = s_frame_start;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg      <= '0;
            fmt_reg      <= ckre_pkg::FMT_RGB32;
            s1_valid_reg <= 1'b0;
        end else begin
            key_reg      <= key_next;
            fmt_reg      <= fmt_next;
            s1_valid_reg <= s1_valid_next;
        end
        s1_word_reg        <= s1_word_next;
        s1_row_end_reg     <= s1_row_end_next;
        s1_frame_start_reg <= s1_frame_start_next;
    end

    ckre_palette u_palette (
        .aclk    (aclk),
        .wr_en   (s_take && !is_pixel),
        .wr_addr (s_palette_slot),
        .wr_data (s_pixel_word),
        .rd_en   (s_take && is_pixel),
        .rd_addr (s_pixel_word[ckre_pkg::SLOT_W-1:0]),
        .rd_data (pal_entry)
    );

    // key arrives as BBGGRR; compare against RRGGBB
    assign key_rgb = {key_reg[7:0], key_reg[15:8], key_reg[23:16]};
    assign key_565 = {key_rgb[23:19], key_rgb[15:10], key_rgb[7:3]};

    always_comb begin
        pal_value = (int'(s1_word_reg[ckre_pkg::SLOT_W-1:0]) < ckre_pkg::PALETTE_DEPTH)
                    ? pal_entry : '0;
        case (fmt_reg)
            ckre_pkg::FMT_PAL8:  opaque = (pal_value != {8'h00, key_rgb});
            ckre_pkg::FMT_RGB16: opaque = (s1_word_reg[15:0] != key_565);
            ckre_pkg::FMT_RGB24: opaque = (s1_word_reg[23:0] != key_rgb);
            default:             opaque = (s1_word_reg != {8'h00, key_rgb});
        endcase
    end

    always_comb begin
        pix.valid       = s1_valid_reg;
        pix.opaque      = opaque;
        pix.row_end     = s1_row_end_reg;
        pix.frame_start = s1_frame_start_reg;
    end

    ckre_run_tracker u_tracker (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .pix         (pix),
        .pix_take    (pix_take),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_run_left  (m_run_left),
        .m_run_right (m_run_right),
        .m_run_row   (m_run_row)
    );

endmodule

/* dv/color_key_run_extractor_core_tb.sv */
// Self-checking testbench for the color key run extractor core.
module color_key_run_extractor_core_tb;

    localparam int SETTLE_CYCLES = 6;
    localparam int IDLE_LIMIT    = 2000;

    localparam int WORD_W    = ckre_pkg::WORD_W;
    localparam int KEY_W     = ckre_pkg::KEY_W;
    localparam int SLOT_W    = ckre_pkg::SLOT_W;
    localparam int COL_W     = ckre_pkg::COL_W;
    localparam int RIGHT_W   = ckre_pkg::RIGHT_W;
    localparam int ROW_W     = ckre_pkg::ROW_W;
    localparam int CFG_IDX_W = ckre_pkg::CFG_IDX_W;

    typedef struct packed {
        ckre_pkg::opcode_t   op;
        logic [WORD_W-1:0]   word;
        logic [SLOT_W-1:0]   slot;
        logic                row_end;
        logic                frame_start;
    } pix_item_t;

    typedef struct packed {
        logic [COL_W-1:0]   left;
        logic [RIGHT_W-1:0] right;
        logic [ROW_W-1:0]   row;
    } run_t;

    typedef struct {
        bit                 is_reg;
        ckre_pkg::cfg_reg_t reg_idx;
        logic [KEY_W-1:0]   reg_data;
        pix_item_t          item;
        bit                 typed;
        bit                 typed_has;
        run_t               typed_run;
    } dir_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [KEY_W-1:0]     cfg_data = '0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    logic                 s_opcode = 1'b0;
    logic [WORD_W-1:0]    s_pixel_word = '0;
    logic [SLOT_W-1:0]    s_palette_slot = '0;
    logic                 s_row_end = 1'b0;
    logic                 s_frame_start = 1'b0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    logic [COL_W-1:0]     m_run_left;
    logic [RIGHT_W-1:0]   m_run_right;
    logic [ROW_W-1:0]     m_run_row;

    color_key_run_extractor_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_opcode       (s_opcode),
        .s_pixel_word   (s_pixel_word),
        .s_palette_slot (s_palette_slot),
        .s_row_end      (s_row_end),
        .s_frame_start  (s_frame_start),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_run_left     (m_run_left),
        .m_run_right    (m_run_right),
        .m_run_row      (m_run_row)
    );

    always #6 aclk = ~aclk;

    // Shadow of the block: configuration, palette and run tracker
    logic [KEY_W-1:0]   key_reg = '0;
    ckre_pkg::pix_fmt_t fmt_reg = ckre_pkg::FMT_RGB32;
    logic [WORD_W-1:0]  pal_mem [ckre_pkg::PALETTE_DEPTH];
    bit                 pal_written [ckre_pkg::PALETTE_DEPTH];
    logic [SLOT_W-1:0]  pal_slots [$];
    int                 col_n = 0;
    int                 row_n = 0;
    bit                 run_on = 1'b0;
    int                 run_from = 0;

    run_t      pending_runs [$];
    dir_row_t  dir_rows [$];
    run_t      want_run;
    int        mismatches = 0;
    int        burst_left = 0;
    int        idle_cycles = 0;
    int        stall_span = 0;
    int        stall_mode = 0;
    int        stall_tick = 0;

    function automatic logic [KEY_W-1:0] swapped_key();
        return {key_reg[7:0], key_reg[15:8], key_reg[23:16]};
    endfunction

    function automatic logic [15:0] key_565();
        logic [KEY_W-1:0] k;
        k = swapped_key();
        return {k[23:19], k[15:10], k[7:3]};
    endfunction

    function automatic bit pixel_opaque(input logic [WORD_W-1:0] word);
        case (fmt_reg)
            ckre_pkg::FMT_PAL8:  return pal_mem[word[7:0]] != {8'h00, swapped_key()};
            ckre_pkg::FMT_RGB16: return word[15:0] != key_565();
            ckre_pkg::FMT_RGB24: return word[23:0] != swapped_key();
            default:             return word != {8'h00, swapped_key()};
        endcase
    endfunction

    // Returns 1 when the item closes a run; the run lands in r
    function automatic bit advance_run_tracker(input pix_item_t it, output run_t r);
        bit closes;
        bit last_px;
        bit opaque;
        closes = 1'b0;
        r = '0;
        if (it.op == ckre_pkg::OP_PAL_WRITE) begin
            pal_mem[it.slot] = it.word;
            if (!pal_written[it.slot]) begin
                pal_written[it.slot] = 1'b1;
                pal_slots.insert(pal_slots.size(), it.slot);
            end
            return 1'b0;
        end
        if (it.frame_start) begin
            col_n = 0;
            row_n = 0;
            run_on = 1'b0;
        end
        last_px = it.row_end || (col_n >= ckre_pkg::MAX_WIDTH - 1);
        opaque = pixel_opaque(it.word);
        if (run_on) begin
            if (!opaque) begin
                r = '{COL_W'(run_from), RIGHT_W'(col_n), ROW_W'(row_n)};
                closes = 1'b1;
                run_on = 1'b0;
            end
        end else if (opaque) begin
            run_from = col_n;
            run_on = 1'b1;
        end
        if (last_px) begin
            if (run_on && opaque) begin
                r = '{COL_W'(run_from), RIGHT_W'(col_n + 1), ROW_W'(row_n)};
                closes = 1'b1;
            end
            run_on = 1'b0;
            col_n = 0;
            row_n = (row_n + 1 >= ckre_pkg::MAX_HEIGHT) ? 0 : row_n + 1;
        end else begin
            col_n = col_n + 1;
        end
        return closes;
    endfunction

    function automatic logic [WORD_W-1:0] make_key_pixel();
        logic [SLOT_W-1:0] hits [$];
        case (fmt_reg)
            ckre_pkg::FMT_PAL8: begin
                foreach (pal_slots[i])
                    if (pal_mem[pal_slots[i]] == {8'h00, swapped_key()})
                        hits.insert(hits.size(), pal_slots[i]);
                if (hits.size() == 0)
                    hits = pal_slots;
                return {24'($urandom()), hits[$urandom_range(0, hits.size() - 1)]};
            end
            ckre_pkg::FMT_RGB16: return {16'($urandom()), key_565()};
            ckre_pkg::FMT_RGB24: return {8'($urandom()), swapped_key()};
            default:             return {8'h00, swapped_key()};
        endcase
    endfunction

    // Near-miss of the key (one bit off) or fully random; in palette format, a written slot
    function automatic logic [WORD_W-1:0] make_plain_pixel();
        int top;
        case (fmt_reg)
            ckre_pkg::FMT_PAL8:
                return {24'($urandom()), pal_slots[$urandom_range(0, pal_slots.size() - 1)]};
            ckre_pkg::FMT_RGB16: top = 15;
            ckre_pkg::FMT_RGB24: top = 23;
            default:             top = 31;
        endcase
        if ($urandom_range(0, 1))
            return make_key_pixel() ^ (32'h1 << $urandom_range(0, top));
        return $urandom();
    endfunction

    function automatic dir_row_t blank_row();
        dir_row_t d;
        d.is_reg    = 1'b0;
        d.reg_idx   = ckre_pkg::REG_KEY_COLOR;
        d.reg_data  = '0;
        d.item      = '0;
        d.typed     = 1'b0;
        d.typed_has = 1'b0;
        d.typed_run = '0;
        return d;
    endfunction

    function automatic void tbl_px(input ckre_pkg::opcode_t op, input logic [WORD_W-1:0] word,
                                   input logic [SLOT_W-1:0] slot, input bit re, input bit fs);
        dir_row_t d;
        d = blank_row();
        d.item = '{op, word, slot, re, fs};
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    function automatic void tbl_fix(input logic [WORD_W-1:0] word, input bit re, input bit fs,
                                    input bit has, input int left, input int right, input int row);
        dir_row_t d;
        d = blank_row();
        d.item = '{ckre_pkg::OP_PIXEL, word, 8'h00, re, fs};
        d.typed = 1'b1;
        d.typed_has = has;
        d.typed_run = '{COL_W'(left), RIGHT_W'(right), ROW_W'(row)};
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    function automatic void tbl_reg(input ckre_pkg::cfg_reg_t idx, input logic [KEY_W-1:0] data);
        dir_row_t d;
        d = blank_row();
        d.is_reg = 1'b1;
        d.reg_idx = idx;
        d.reg_data = data;
        dir_rows.insert(dir_rows.size(), d);
    endfunction

    // Hold the sender until every run has come out and the pipeline is empty
    task automatic settle();
        s_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input ckre_pkg::cfg_reg_t idx, input logic [KEY_W-1:0] data);
        settle();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == ckre_pkg::REG_KEY_COLOR)
            key_reg = data;
        else
            fmt_reg = ckre_pkg::pix_fmt_t'(data[1:0]);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic offer_item(input pix_item_t it, input bit typed, input bit typed_has,
                              input run_t typed_run);
        run_t r;
        bit   got;
        s_valid        <= 1'b1;
        s_opcode       <= it.op;
        s_pixel_word   <= it.word;
        s_palette_slot <= it.slot;
        s_row_end      <= it.row_end;
        s_frame_start  <= it.frame_start;
        do @(posedge aclk); while (!s_ready);
        got = advance_run_tracker(it, r);
        if (typed) begin
            got = typed_has;
            r = typed_run;
        end
        if (got)
            pending_runs.insert(pending_runs.size(), r);
        burst_left--;
        if ($urandom_range(0, 199) == 0) begin
            settle();
        end else if (burst_left <= 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end
    endtask

    // Rows of random width with random content and palette writes; a few broken rows and frames
    task automatic stream_rows(input int n_pixels);
        pix_item_t it;
        int        width;
        bit        new_frame;
        int        sent;
        sent = 0;
        while (sent < n_pixels) begin
            width = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 48) : $urandom_range(1, 8);
            new_frame = ($urandom_range(0, 5) == 0);
            for (int c = 0; c < width; c++) begin
                if ($urandom_range(0, 11) == 0) begin
                    it.op = ckre_pkg::OP_PAL_WRITE;
                    it.slot = SLOT_W'($urandom());
                    it.word = ($urandom_range(0, 2) == 0) ? {8'h00, swapped_key()} : $urandom();
                    it.row_end = 1'($urandom());
                    it.frame_start = 1'($urandom());
                    offer_item(it, 1'b0, 1'b0, '0);
                end
                it.op = ckre_pkg::OP_PIXEL;
                it.slot = SLOT_W'($urandom());
                it.word = ($urandom_range(0, 9) < 4) ? make_key_pixel() : make_plain_pixel();
                it.row_end = (c == width - 1);
                it.frame_start = new_frame && (c == 0);
                if ($urandom_range(0, 19) == 0)
                    it.row_end = 1'($urandom());
                if ($urandom_range(0, 29) == 0)
                    it.frame_start = 1'b1;
                offer_item(it, 1'b0, 1'b0, '0);
                sent++;
            end
        end
    endtask

    // Receiver stall pattern: always ready, mostly ready, periodically ready, mostly stalled
    always @(posedge aclk) begin
        if (stall_span == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_span <= $urandom_range(16, 96);
        end else begin
            stall_span <= stall_span - 1;
        end
        stall_tick <= stall_tick + 1;
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 9) < 7);
            2: m_ready <= (stall_tick % 3 == 0);
            default: m_ready <= ($urandom_range(0, 9) < 3);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_runs.size() == 0) begin
                $error("unexpected run: left %0d right %0d row %0d",
                       m_run_left, m_run_right, m_run_row);
                mismatches++;
            end else begin
                want_run = pending_runs.pop_front();
                if (m_run_left !== want_run.left) begin
                    $error("run_left: expected %0d, got %0d", want_run.left, m_run_left);
                    mismatches++;
                end
                if (m_run_right !== want_run.right) begin
                    $error("run_right: expected %0d, got %0d", want_run.right, m_run_right);
                    mismatches++;
                end
                if (m_run_row !== want_run.row) begin
                    $error("run_row: expected %0d, got %0d", want_run.row, m_run_row);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        ckre_pkg::pix_fmt_t phase_fmt [6];
        logic [KEY_W-1:0]   phase_key;

        phase_fmt = '{ckre_pkg::FMT_PAL8, ckre_pkg::FMT_RGB16, ckre_pkg::FMT_RGB24,
                      ckre_pkg::FMT_RGB32, ckre_pkg::FMT_RGB16, ckre_pkg::FMT_PAL8};

        // Reset state: 32-bit format, key zero
        tbl_fix(32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, 0, 0, 0);
        tbl_fix(32'h0000_0000, 1'b0, 1'b0, 1'b1, 0, 1, 0);
        tbl_fix(32'h0000_0001, 1'b1, 1'b0, 1'b1, 2, 3, 0);
        tbl_fix(32'h8000_0000, 1'b1, 1'b0, 1'b1, 0, 1, 1);
        tbl_fix(32'h0000_0000, 1'b1, 1'b0, 1'b0, 0, 0, 0);
        tbl_px(ckre_pkg::OP_PIXEL, 32'h1234_5678, 8'h00, 1'b0, 1'b1);
        // Palette write ignores its row end and frame start flags
        tbl_px(ckre_pkg::OP_PAL_WRITE, 32'hDEAD_BEEF, 8'hFF, 1'b1, 1'b1);
        // Frame start drops the open run silently
        tbl_fix(32'hAAAA_AAAA, 1'b0, 1'b1, 1'b0, 0, 0, 0);
        tbl_fix(32'h5555_5555, 1'b1, 1'b0, 1'b1, 0, 2, 0);
        tbl_px(ckre_pkg::OP_PAL_WRITE, 32'h0000_0000, 8'h00, 1'b0, 1'b0);
        tbl_px(ckre_pkg::OP_PAL_WRITE, 32'hFFFF_FFFF, 8'hFF, 1'b0, 1'b0);
        tbl_px(ckre_pkg::OP_PAL_WRITE, 32'h00AB_CDEF, 8'h5A, 1'b0, 1'b0);
        tbl_reg(ckre_pkg::REG_KEY_COLOR, 24'hEFCDAB);
        tbl_reg(ckre_pkg::REG_PIXEL_FORMAT, KEY_W'(ckre_pkg::FMT_PAL8));
        tbl_px(ckre_pkg::OP_PIXEL, 32'hFFFF_FF5A, 8'h00, 1'b0, 1'b1);
        tbl_px(ckre_pkg::OP_PIXEL, 32'h0000_00FF, 8'h00, 1'b0, 1'b0);
        tbl_px(ckre_pkg::OP_PIXEL, 32'h0000_005A, 8'h00, 1'b0, 1'b0);
        tbl_px(ckre_pkg::OP_PIXEL, 32'h0000_0000, 8'h00, 1'b1, 1'b0);
        // Rewrite a slot and read it on the very next transaction
        tbl_px(ckre_pkg::OP_PAL_WRITE, 32'h0000_0000, 8'h5A, 1'b0, 1'b0);
        tbl_px(ckre_pkg::OP_PIXEL, 32'h0000_005A, 8'hFF, 1'b1, 1'b0);
        tbl_reg(ckre_pkg::REG_PIXEL_FORMAT, KEY_W'(ckre_pkg::FMT_RGB16));
        tbl_reg(ckre_pkg::REG_KEY_COLOR, 24'hFFFFFF);
        tbl_px(ckre_pkg::OP_PIXEL, 32'hABCD_FFFF, 8'h00, 1'b0, 1'b1);
        tbl_px(ckre_pkg::OP_PIXEL, 32'h0000_FFFE, 8'h00, 1'b0, 1'b0);
        tbl_px(ckre_pkg::OP_PIXEL, 32'h0000_FFFF, 8'h00, 1'b1, 1'b0);
        // Low color bits vanish in the 5:6:5 reduction
        tbl_reg(ckre_pkg::REG_KEY_COLOR, 24'h070307);
        tbl_px(ckre_pkg::OP_PIXEL, 32'h0000_0000, 8'h00, 1'b0, 1'b1);
        tbl_px(ckre_pkg::OP_PIXEL, 32'h0000_0001, 8'h00, 1'b1, 1'b0);
        tbl_reg(ckre_pkg::REG_PIXEL_FORMAT, KEY_W'(ckre_pkg::FMT_RGB24));
        tbl_reg(ckre_pkg::REG_KEY_COLOR, 24'h112233);
        tbl_px(ckre_pkg::OP_PIXEL, 32'hFF33_2211, 8'h00, 1'b0, 1'b1);
        tbl_px(ckre_pkg::OP_PIXEL, 32'h0033_2210, 8'h00, 1'b1, 1'b0);
        tbl_reg(ckre_pkg::REG_PIXEL_FORMAT, KEY_W'(ckre_pkg::FMT_RGB32));
        tbl_px(ckre_pkg::OP_PIXEL, 32'h0133_2211, 8'h00, 1'b1, 1'b1);
        tbl_px(ckre_pkg::OP_PIXEL, 32'h0033_2211, 8'h00, 1'b1, 1'b0);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_reg)
                write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
            else
                offer_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].typed_has,
                           dir_rows[i].typed_run);
        end

        for (int p = 0; p < 6; p++) begin
            if (p == 1)
                phase_key = 24'h000000;
            else if (p == 2 || p == 5)
                phase_key = 24'hFFFFFF;
            else
                phase_key = KEY_W'($urandom());
            write_reg(ckre_pkg::REG_PIXEL_FORMAT, KEY_W'(phase_fmt[p]));
            write_reg(ckre_pkg::REG_KEY_COLOR, phase_key);
            stream_rows(65);
        end

        settle();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
